[rtl/core/pbc_pkg.sv]
// ----------------------------------------------------------------------------
// Page buffer cache package
// Shared widths, codes and the slot entry layout.
// ----------------------------------------------------------------------------
package pbc_pkg;

   localparam int MaxSlots  = 64;
   localparam int GrowStep  = 8;
   localparam int IdxW      = 6;
   localparam int CntW      = 7;
   localparam int FileW     = 16;
   localparam int PageW     = 12;
   localparam int AgeW      = 31;
   localparam int PinW      = 8;
   localparam int ChunkW    = 24;
   localparam int PageShift = 11;

   localparam logic [2:0] OP_READ      = 3'd0;
   localparam logic [2:0] OP_NEW       = 3'd1;
   localparam logic [2:0] OP_RELEASE   = 3'd2;
   localparam logic [2:0] OP_ZAP       = 3'd3;
   localparam logic [2:0] OP_FLUSH     = 3'd4;
   localparam logic [2:0] OP_FLUSH_ALL = 3'd5;

   localparam logic [1:0] KIND_GRANT = 2'd0;
   localparam logic [1:0] KIND_WB    = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [1:0] ST_HIT     = 2'd0;
   localparam logic [1:0] ST_ALLOC   = 2'd1;
   localparam logic [1:0] ST_PASTEND = 2'd2;
   localparam logic [1:0] ST_NOSLOT  = 2'd3;

   typedef struct packed {
      logic [FileW-1:0] file;
      logic [PageW-1:0] page;
      logic [AgeW-1:0]  age;
      logic [PinW-1:0]  pins;
   } entry_type;

   localparam int EntryW = $bits(entry_type);

endpackage

[rtl/core/pbc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/page_buffer_cache_lru.sv]
// ----------------------------------------------------------------------------
// Page buffer cache LRU engine
// Tag lookup, victim choice, pin counts and write-back requests for a pool
// of up to 64 page slots.
// ----------------------------------------------------------------------------
// Requests enter on the req_ channel (op on req_tuser) and results leave on
// the rsp_ channel (kind on rsp_tuser, rsp_tlast on the final result).
// Read, new page, zap and flush scan the active slots through one entry RAM
// port, one slot per cycle. Release reads the slot and writes it back with
// its pin count decremented. req_tready is high only while the engine is
// idle; the result register lets the next item enter while the last result
// still waits. A stalled receiver holds the scan at the slot whose
// write-back cannot be posted yet.
// Reset empties the pool: all slots invalid, clean, unpinned and of age
// zero, time counter one, no grown slots, initial_slots 16. No clearing
// pass is needed. csr_wr_en writes initial_slots; write it only when idle.
// ----------------------------------------------------------------------------
module page_buffer_cache_lru
   import pbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // file_id, page, chunk_bytes, slot_in, mark_dirty, pad
   input  logic [2:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // status, slot, wb_file_id, wb_page, pad
   output logic [1:0]  rsp_tuser,  // kind
   output logic        rsp_tlast
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_WB, S_GRANT, S_REL_RD, S_REL_WR, S_DONE, S_FL_END
   } state_type;

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [FileW-1:0]  file_ff, file_in;
   logic [PageW-1:0]  page_ff, page_in;
   logic [ChunkW-1:0] chunk_ff, chunk_in;
   logic [IdxW-1:0]   sin_ff, sin_in;
   logic              mark_ff, mark_in;
   logic [CntW-1:0]   rd_idx_ff, rd_idx_in;
   logic              ev_vld_ff, ev_vld_in;
   logic [IdxW-1:0]   ev_idx_ff, ev_idx_in;
   logic              hit_found_ff, hit_found_in;
   logic [IdxW-1:0]   hit_idx_ff, hit_idx_in;
   logic [PinW-1:0]   hit_pins_ff, hit_pins_in;
   logic              vic_found_ff, vic_found_in;
   logic [IdxW-1:0]   vic_idx_ff, vic_idx_in;
   logic [AgeW-1:0]   vic_age_ff, vic_age_in;
   logic              vic_wb_ff, vic_wb_in;
   logic [FileW-1:0]  vic_file_ff, vic_file_in;
   logic [PageW-1:0]  vic_page_ff, vic_page_in;
   logic              pend_ff, pend_in;
   logic [IdxW-1:0]   pend_idx_ff, pend_idx_in;
   logic [FileW-1:0]  pend_file_ff, pend_file_in;
   logic [PageW-1:0]  pend_page_ff, pend_page_in;
   logic [1:0]        gstat_ff, gstat_in;
   logic [IdxW-1:0]   gslot_ff, gslot_in;
   logic [MaxSlots-1:0] valid_ff, valid_in, dirty_ff, dirty_in;
   logic [MaxSlots-1:0] init_ff, init_in, aclr_ff, aclr_in;
   logic [AgeW-1:0]   tc_ff, tc_in;
   logic [CntW-1:0]   grown_ff, grown_in;
   logic [6:0]        cfg_ff, cfg_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in, rsp_status_ff, rsp_status_in;
   logic [IdxW-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [FileW-1:0]  rsp_file_ff, rsp_file_in;
   logic [PageW-1:0]  rsp_page_ff, rsp_page_in;
   logic              rsp_last_ff, rsp_last_in;

   logic            ram_we;
   logic [IdxW-1:0] ram_waddr, ram_raddr;
   entry_type       ram_wdata, ram_rdata;

   logic [7:0]      cfg_v, base;
   logic [9:0]      limit_x4;
   logic [8:0]      act_sum;
   logic [CntW-1:0] nb, limit;
   logic            out_free;
   logic [AgeW-1:0] age_eff, tick_t;
   logic [PinW-1:0] pins_eff;
   logic            e_valid, e_dirty, f_match, pastend;
   logic [7:0]      grow_end;

   pbc_ram #(.WIDTH(EntryW), .DEPTH(MaxSlots)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      cfg_v    = (cfg_ff == 7'd0) ? 8'd1 : {1'b0, cfg_ff};
      base     = (cfg_v + 8'd7) & 8'hF8;
      if (base > 8'(MaxSlots)) begin
         base = 8'(MaxSlots);
      end
      limit_x4 = {base, 2'b00};
      limit    = (limit_x4 > 10'(MaxSlots)) ? CntW'(MaxSlots) : limit_x4[CntW-1:0];
      act_sum  = {1'b0, base} + {2'b00, grown_ff};
      nb       = (act_sum > 9'(MaxSlots)) ? CntW'(MaxSlots) : act_sum[CntW-1:0];
      grow_end = {1'b0, nb} + 8'(GrowStep);
   end

   assign out_free = !rsp_vld_ff || rsp_tready;
   assign age_eff  = (!init_ff[ev_idx_ff] || aclr_ff[ev_idx_ff]) ? '0 : ram_rdata.age;
   assign pins_eff = init_ff[ev_idx_ff] ? ram_rdata.pins : '0;
   assign e_valid  = valid_ff[ev_idx_ff];
   assign e_dirty  = dirty_ff[ev_idx_ff];
   assign f_match  = e_valid && (ram_rdata.file == file_ff);
   assign pastend  = ({1'b0, page_ff, PageShift'(0)} >= chunk_ff);
   assign tick_t   = (tc_ff == '0) ? AgeW'(1) : tc_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0, rsp_page_ff, rsp_file_ff, rsp_slot_ff, rsp_status_ff};

   always_comb begin
      state_in = state_ff;   op_in = op_ff;       file_in = file_ff;
      page_in = page_ff;     chunk_in = chunk_ff; sin_in = sin_ff;
      mark_in = mark_ff;     rd_idx_in = rd_idx_ff;
      ev_vld_in = 1'b0;      ev_idx_in = ev_idx_ff;
      hit_found_in = hit_found_ff; hit_idx_in = hit_idx_ff; hit_pins_in = hit_pins_ff;
      vic_found_in = vic_found_ff; vic_idx_in = vic_idx_ff; vic_age_in = vic_age_ff;
      vic_wb_in = vic_wb_ff; vic_file_in = vic_file_ff; vic_page_in = vic_page_ff;
      pend_in = pend_ff;     pend_idx_in = pend_idx_ff;
      pend_file_in = pend_file_ff; pend_page_in = pend_page_ff;
      gstat_in = gstat_ff;   gslot_in = gslot_ff;
      valid_in = valid_ff;   dirty_in = dirty_ff; init_in = init_ff; aclr_in = aclr_ff;
      tc_in = tc_ff;         grown_in = grown_ff;
      cfg_in = csr_wr_en ? csr_wr_data : cfg_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff; rsp_status_in = rsp_status_ff;
      rsp_slot_in = rsp_slot_ff; rsp_file_in = rsp_file_ff;
      rsp_page_in = rsp_page_ff; rsp_last_in = rsp_last_ff;
      ram_we = 1'b0;         ram_waddr = ev_idx_ff;
      ram_wdata = ram_rdata; ram_raddr = rd_idx_ff[IdxW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               file_in  = req_tdata[15:0];
               page_in  = req_tdata[27:16];
               chunk_in = req_tdata[51:28];
               sin_in   = req_tdata[57:52];
               mark_in  = req_tdata[58];
               rd_idx_in = '0;
               hit_found_in = 1'b0;
               vic_found_in = 1'b0;
               pend_in = 1'b0;
               unique case (req_tuser) inside
                  OP_READ, OP_NEW, OP_ZAP, OP_FLUSH, OP_FLUSH_ALL: state_in = S_SCAN;
                  OP_RELEASE: begin
                     state_in = ({1'b0, req_tdata[57:52]} < nb) ? S_REL_RD : S_DONE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            if (rd_idx_ff < nb) begin
               ev_vld_in = 1'b1;
               ev_idx_in = rd_idx_ff[IdxW-1:0];
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (ev_vld_ff) begin
               case (op_ff) inside
                  OP_ZAP: begin
                     if (f_match) begin
                        valid_in[ev_idx_ff] = 1'b0;
                        dirty_in[ev_idx_ff] = 1'b0;
                     end
                  end
                  OP_FLUSH, OP_FLUSH_ALL: begin
                     if (op_ff == OP_FLUSH_ALL || f_match) begin
                        if (e_dirty && e_valid && pend_ff && !out_free) begin
                           // hold: re-read this slot once the result register frees
                           ev_vld_in = 1'b0;
                           rd_idx_in = {1'b0, ev_idx_ff};
                        end else begin
                           dirty_in[ev_idx_ff] = 1'b0;
                           if (e_dirty && e_valid) begin
                              if (pend_ff) begin
                                 rsp_vld_in = 1'b1;    rsp_kind_in = KIND_WB;
                                 rsp_status_in = '0;   rsp_slot_in = pend_idx_ff;
                                 rsp_file_in = pend_file_ff; rsp_page_in = pend_page_ff;
                                 rsp_last_in = 1'b0;
                              end
                              pend_in = 1'b1;
                              pend_idx_in = ev_idx_ff;
                              pend_file_in = ram_rdata.file;
                              pend_page_in = ram_rdata.page;
                           end
                        end
                     end
                  end
                  default: begin
                     if (!hit_found_ff && f_match && ram_rdata.page == page_ff) begin
                        hit_found_in = 1'b1;
                        hit_idx_in = ev_idx_ff;
                        hit_pins_in = ram_rdata.pins;
                     end
                     if (pins_eff == '0 && (!vic_found_ff ||
                         (tc_ff != '0 && age_eff < vic_age_ff))) begin
                        vic_found_in = 1'b1;
                        vic_idx_in = ev_idx_ff;
                        vic_age_in = age_eff;
                        vic_wb_in = e_valid && e_dirty;
                        vic_file_in = ram_rdata.file;
                        vic_page_in = ram_rdata.page;
                     end
                  end
               endcase
            end
            if (!ev_vld_in && !(rd_idx_ff < nb) && !(ev_vld_ff && rd_idx_in != rd_idx_ff + 1'b1
                && rd_idx_in != rd_idx_ff)) begin
               if (!ev_vld_ff || rd_idx_in == rd_idx_ff) begin
                  case (op_ff) inside
                     OP_ZAP:                 state_in = S_DONE;
                     OP_FLUSH, OP_FLUSH_ALL: state_in = S_FL_END;
                     default:                state_in = S_DECIDE;
                  endcase
               end
            end
         end
         S_DECIDE: begin
            if (op_ff == OP_READ && hit_found_ff) begin
               ram_we = 1'b1;
               ram_waddr = hit_idx_ff;
               ram_wdata.file = file_ff;
               ram_wdata.page = page_ff;
               ram_wdata.age = tc_ff;
               ram_wdata.pins = (init_ff[hit_idx_ff] ? hit_pins_ff : '0);
               if (ram_wdata.pins != '1) begin
                  ram_wdata.pins = ram_wdata.pins + 1'b1;
               end
               init_in[hit_idx_ff] = 1'b1;
               aclr_in[hit_idx_ff] = 1'b0;
               if (tc_ff != '0) begin
                  tc_in = tc_ff + 1'b1;
               end
               gstat_in = ST_HIT;
               gslot_in = hit_idx_ff;
               state_in = S_GRANT;
            end else begin
               if (tc_ff == '0) begin
                  tc_in = AgeW'(1);
                  for (int i = 0; i < MaxSlots; i++) begin
                     if (i < int'(nb)) begin
                        aclr_in[i] = 1'b1;
                     end
                  end
               end
               if (!vic_found_ff && grow_end > {1'b0, limit}) begin
                  gstat_in = ST_NOSLOT;
                  gslot_in = '0;
                  state_in = S_GRANT;
               end else begin
                  if (!vic_found_ff) begin
                     for (int i = 0; i < MaxSlots; i++) begin
                        if (i >= int'(nb) && i < int'(grow_end)) begin
                           valid_in[i] = 1'b0;
                           dirty_in[i] = 1'b0;
                           init_in[i] = 1'b0;
                        end
                     end
                     vic_idx_in = nb[IdxW-1:0];
                     vic_wb_in = 1'b0;
                     grown_in = grown_ff + CntW'(GrowStep);
                  end
                  ram_we = 1'b1;
                  ram_waddr = vic_found_ff ? vic_idx_ff : nb[IdxW-1:0];
                  ram_wdata.file = file_ff;
                  ram_wdata.page = page_ff;
                  ram_wdata.age = tick_t;
                  tc_in = tick_t + 1'b1;
                  init_in[ram_waddr] = 1'b1;
                  aclr_in[ram_waddr] = 1'b0;
                  dirty_in[ram_waddr] = 1'b0;
                  gslot_in = ram_waddr;
                  if (op_ff == OP_READ && pastend) begin
                     valid_in[ram_waddr] = 1'b0;
                     ram_wdata.pins = '0;
                     gstat_in = ST_PASTEND;
                  end else begin
                     valid_in[ram_waddr] = 1'b1;
                     ram_wdata.pins = PinW'(1);
                     gstat_in = ST_ALLOC;
                  end
                  state_in = (vic_found_ff && vic_wb_ff) ? S_WB : S_GRANT;
               end
            end
         end
         S_WB: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;    rsp_kind_in = KIND_WB;
               rsp_status_in = '0;   rsp_slot_in = vic_idx_ff;
               rsp_file_in = vic_file_ff; rsp_page_in = vic_page_ff;
               rsp_last_in = 1'b0;
               state_in = S_GRANT;
            end
         end
         S_GRANT: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;    rsp_kind_in = KIND_GRANT;
               rsp_status_in = gstat_ff; rsp_slot_in = gslot_ff;
               rsp_file_in = '0;     rsp_page_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_REL_RD: begin
            ram_raddr = sin_ff;
            ev_idx_in = sin_ff;
            state_in = S_REL_WR;
         end
         S_REL_WR: begin
            ram_we = 1'b1;
            ram_waddr = sin_ff;
            ram_wdata.age = age_eff;
            ram_wdata.pins = (pins_eff != '0) ? pins_eff - 1'b1 : '0;
            init_in[sin_ff] = 1'b1;
            aclr_in[sin_ff] = 1'b0;
            if (mark_ff) begin
               dirty_in[sin_ff] = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;    rsp_kind_in = KIND_DONE;
               rsp_status_in = '0;   rsp_slot_in = '0;
               rsp_file_in = '0;     rsp_page_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FL_END: begin
            if (!pend_ff) begin
               state_in = S_DONE;
            end else if (out_free) begin
               rsp_vld_in = 1'b1;    rsp_kind_in = KIND_WB;
               rsp_status_in = '0;   rsp_slot_in = pend_idx_ff;
               rsp_file_in = pend_file_ff; rsp_page_in = pend_page_ff;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ev_vld_ff  <= 1'b0;
         valid_ff   <= '0;
         dirty_ff   <= '0;
         init_ff    <= '0;
         aclr_ff    <= '0;
         tc_ff      <= AgeW'(1);
         grown_ff   <= '0;
         cfg_ff     <= 7'd16;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         ev_vld_ff  <= ev_vld_in;
         valid_ff   <= valid_in;
         dirty_ff   <= dirty_in;
         init_ff    <= init_in;
         aclr_ff    <= aclr_in;
         tc_ff      <= tc_in;
         grown_ff   <= grown_in;
         cfg_ff     <= cfg_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      op_ff <= op_in;   file_ff <= file_in;   page_ff <= page_in;
      chunk_ff <= chunk_in; sin_ff <= sin_in; mark_ff <= mark_in;
      rd_idx_ff <= rd_idx_in; ev_idx_ff <= ev_idx_in;
      hit_found_ff <= hit_found_in; hit_idx_ff <= hit_idx_in; hit_pins_ff <= hit_pins_in;
      vic_found_ff <= vic_found_in; vic_idx_ff <= vic_idx_in; vic_age_ff <= vic_age_in;
      vic_wb_ff <= vic_wb_in; vic_file_ff <= vic_file_in; vic_page_ff <= vic_page_in;
      pend_ff <= pend_in; pend_idx_ff <= pend_idx_in;
      pend_file_ff <= pend_file_in; pend_page_ff <= pend_page_in;
      gstat_ff <= gstat_in; gslot_ff <= gslot_in;
      rsp_kind_ff <= rsp_kind_in; rsp_status_ff <= rsp_status_in;
      rsp_slot_ff <= rsp_slot_in; rsp_file_ff <= rsp_file_in;
      rsp_page_ff <= rsp_page_in; rsp_last_ff <= rsp_last_in;
   end

endmodule
